@@ hw/rtl/sha256_stream_hasher_assert.svh @@
// Assertion macros for the SHA-256 stream hasher.
// Depends on clk and rst_n in the using module.
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SHA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHA_ASSERT(label, prop, msg)
`define SHA_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ hw/rtl/sha_pkg.sv @@
// Shared types, constants and round functions of the SHA-256 hasher.
// No dependencies.
`default_nettype none
package sha_pkg;
  localparam logic [1:0] SRC_MSG   = 2'd0;
  localparam logic [1:0] SRC_PAD80 = 2'd1;
  localparam logic [1:0] SRC_ZERO  = 2'd2;
  localparam logic [1:0] SRC_LEN   = 2'd3;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef struct packed {
    logic       shift;
    logic [1:0] src;
    logic       len_inc;
    logic       comp_start;
    logic       round;
    logic [5:0] rnd;
    logic       add;
    logic       dbl_load;
    logic       finish;
    logic [2:0] wsel;
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0] cnt;
  } sha_sts_t;

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] h;
    unique case (i)
      3'd0: h = 32'h6a09e667;
      3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372;
      3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f;
      3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] sml_sig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sml_sig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction
endpackage
`default_nettype wire

@@ hw/rtl/sha_dp.sv @@
// SHA-256 datapath: byte block shifter, length counter, schedule, rounds.
// Depends on sha_pkg.
`default_nettype none
module sha_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sha_pkg::sha_cmd_t cmd,
  input  wire logic [7:0]        data_byte,
  output sha_pkg::sha_sts_t      sts,
  output logic [31:0]            digest_word
);
  logic [511:0] blk_r, blk_nxt;
  logic [5:0]   cnt_r;
  logic [63:0]  len_r;
  logic [31:0]  cv_r [8];
  logic [31:0]  v_r  [8];
  logic [31:0]  w_r  [16];
  logic [31:0]  sum  [8];
  logic [7:0]   byte_in;
  logic [31:0]  t1, t2, w_new;

  always_comb begin
    unique case (cmd.src)
      sha_pkg::SRC_MSG:   byte_in = data_byte;
      sha_pkg::SRC_PAD80: byte_in = sha_pkg::PAD_BYTE;
      sha_pkg::SRC_ZERO:  byte_in = 8'h00;
      default:            byte_in = len_r[{~cnt_r[2:0], 3'b000} +: 8];
    endcase
    for (int i = 0; i < 8; i++) begin
      sum[i] = cv_r[i] + v_r[i];
    end
    blk_nxt = cmd.shift ? {blk_r[503:0], byte_in} : blk_r;
    if (cmd.dbl_load) begin
      blk_nxt[255:0] = {sum[0], sum[1], sum[2], sum[3],
                        sum[4], sum[5], sum[6], sum[7]};
    end
    t1 = v_r[7] + sha_pkg::big_sig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
       + sha_pkg::round_k(cmd.rnd) + w_r[0];
    t2 = sha_pkg::big_sig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    w_new = sha_pkg::sml_sig1(w_r[14]) + w_r[9] + sha_pkg::sml_sig0(w_r[1]) + w_r[0];
  end

  assign sts.cnt     = cnt_r;
  assign digest_word = cv_r[cmd.wsel];

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    if (cmd.comp_start) begin
      for (int i = 0; i < 16; i++) begin
        w_r[i] <= blk_nxt[511 - 32*i -: 32];
      end
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= cv_r[i];
      end
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= w_new;
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      len_r <= '0;
      for (int i = 0; i < 8; i++) begin
        cv_r[i] <= sha_pkg::init_hash(3'(i));
      end
    end else if (cmd.finish) begin
      cnt_r <= '0;
      len_r <= '0;
      for (int i = 0; i < 8; i++) begin
        cv_r[i] <= sha_pkg::init_hash(3'(i));
      end
    end else if (cmd.dbl_load) begin
      cnt_r <= 6'd32;
      len_r <= 64'd256;
      for (int i = 0; i < 8; i++) begin
        cv_r[i] <= sha_pkg::init_hash(3'(i));
      end
    end else begin
      if (cmd.shift) begin
        cnt_r <= cnt_r + 6'd1;
      end
      if (cmd.len_inc) begin
        len_r <= len_r + 64'd8;
      end
      if (cmd.add) begin
        for (int i = 0; i < 8; i++) begin
          cv_r[i] <= sum[i];
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/sha_ctrl.sv @@
// SHA-256 controller: message intake, padding sequence, rounds, digest readout.
// Depends on sha_pkg and sha256_stream_hasher_assert.svh.
`default_nettype none
`include "sha256_stream_hasher_assert.svh"
module sha_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              dbl_en,
  input  wire logic              in_tvalid,
  input  wire logic              in_present,
  input  wire logic              in_end,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [2:0]             out_num,
  output logic                   out_last,
  input  wire sha_pkg::sha_sts_t sts,
  output sha_pkg::sha_cmd_t      cmd
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROUND = 3'd1;
  localparam logic [2:0] ST_ADD   = 3'd2;
  localparam logic [2:0] ST_PAD   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [1:0] RET_IDLE = 2'd0;
  localparam logic [1:0] RET_PAD  = 2'd1;
  localparam logic [1:0] RET_FIN  = 2'd2;

  logic [2:0] state_r, state_nxt;
  logic [1:0] ret_r, ret_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] wcnt_r, wcnt_nxt;
  logic       first_r, first_nxt;
  logic       lenok_r, lenok_nxt;
  logic       dbl_r, dbl_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_num    = wcnt_r;
  assign out_last   = (wcnt_r == 3'd7);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    rnd_nxt   = rnd_r;
    wcnt_nxt  = wcnt_r;
    first_nxt = first_r;
    lenok_nxt = lenok_r;
    dbl_nxt   = dbl_r;
    cmd       = '0;
    cmd.src   = sha_pkg::SRC_MSG;
    cmd.rnd   = rnd_r;
    cmd.wsel  = wcnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.shift   = in_present;
          cmd.len_inc = in_present;
          first_nxt   = 1'b1;
          dbl_nxt     = 1'b0;
          if (in_present && sts.cnt == 6'd63) begin
            cmd.comp_start = 1'b1;
            rnd_nxt   = '0;
            ret_nxt   = in_end ? RET_PAD : RET_IDLE;
            state_nxt = ST_ROUND;
          end else if (in_end) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.shift = 1'b1;
        if (first_r) begin
          cmd.src   = sha_pkg::SRC_PAD80;
          first_nxt = 1'b0;
          lenok_nxt = (sts.cnt <= 6'd55);
        end else if (lenok_r && sts.cnt >= 6'd56) begin
          cmd.src = sha_pkg::SRC_LEN;
        end else begin
          cmd.src = sha_pkg::SRC_ZERO;
        end
        if (sts.cnt == 6'd63) begin
          cmd.comp_start = 1'b1;
          rnd_nxt   = '0;
          ret_nxt   = (lenok_r && !first_r) ? RET_FIN : RET_PAD;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        priority if (ret_r == RET_PAD) begin
          lenok_nxt = 1'b1;
          state_nxt = ST_PAD;
        end else if (ret_r == RET_FIN) begin
          if (dbl_en && !dbl_r) begin
            dbl_nxt   = 1'b1;
            first_nxt = 1'b1;
            state_nxt = ST_PAD;
          end else begin
            wcnt_nxt  = '0;
            state_nxt = ST_OUT;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          wcnt_nxt = wcnt_r + 3'd1;
          if (wcnt_r == 3'd7) begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // load the finished first digest into the block for the second pass
    if (state_r == ST_ADD && ret_r == RET_FIN && dbl_en && !dbl_r) begin
      cmd.dbl_load = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= RET_IDLE;
      rnd_r   <= '0;
      wcnt_r  <= '0;
      first_r <= 1'b0;
      lenok_r <= 1'b0;
      dbl_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      rnd_r   <= rnd_nxt;
      wcnt_r  <= wcnt_nxt;
      first_r <= first_nxt;
      lenok_r <= lenok_nxt;
      dbl_r   <= dbl_nxt;
    end
  end

  `SHA_ASSERT(a_rounds_end, (state_r == ST_ROUND && rnd_r == 6'd63) |=> (state_r == ST_ADD), "round count overrun")
  `SHA_ASSERT(a_out_excl, out_tvalid |-> !in_tready, "intake open while digest pending")
  `SHA_ASSERT(a_last_idle, (out_tvalid && out_tready && out_last) |=> (state_r == ST_IDLE), "no return to idle after digest")
  `SHA_ASSERT(a_pad_no_len_early, (state_r == ST_PAD && first_r) |-> (cmd.src == sha_pkg::SRC_PAD80), "pad marker missing")
endmodule
`default_nettype wire

@@ hw/rtl/sha256_stream_hasher.sv @@
// Top level of the SHA-256 stream hasher: APB register, controller, datapath.
// Depends on sha_pkg, sha_ctrl and sha_dp.
//
//  channel  | transfer                       | payload
//  in_      | in_tvalid && in_tready         | tdata: data_byte; tuser: byte_present;
//           |                                | tlast: end_of_message
//  out_     | out_tvalid && out_tready       | tdata: digest_word; tuser: word_number;
//           |                                | tlast: last_word
//  cfg_     | psel && penable && pwrite      | 0x0: double_hash
//
// Message bytes are taken while intake is open; the 64th byte of a block starts its rounds.
// Padding shifts one byte per cycle into the block shifter, and each padded block is compressed.
// Double mode loads the first digest into the block, adds 32 padding bytes and one more compression.
// Intake is closed from the final item until the eighth digest word transfers.
// Reset is synchronous, active low; it loads the initial hash and clears length and fill.
`default_nettype none
module sha256_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [0:0]  in_tuser,   // [0] byte_present
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] digest_word
  output logic [2:0]       out_tuser,  // [2:0] word_number
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  sha_pkg::sha_cmd_t cmd;
  sha_pkg::sha_sts_t sts;
  logic              dbl_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'd0, dbl_r & ~cfg_paddr[2]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbl_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == 1'b0) begin
      dbl_r <= cfg_pwdata[0];
    end
  end

  sha_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .dbl_en     (dbl_r),
    .in_tvalid  (in_tvalid),
    .in_present (in_tuser[0]),
    .in_end     (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_num    (out_tuser),
    .out_last   (out_tlast),
    .sts        (sts),
    .cmd        (cmd)
  );

  sha_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_tdata),
    .sts         (sts),
    .digest_word (out_tdata)
  );
endmodule
`default_nettype wire
